@@ rtl/core/hex_record_parser_top_defines.svh @@
// assertion macros shared by the record parser rtl
// needs aclk and aresetn in the module that uses them
`ifndef HEX_RECORD_PARSER_TOP_DEFINES_SVH
`define HEX_RECORD_PARSER_TOP_DEFINES_SVH

// same-cycle check, idle during reset
`define HRP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// antecedent now, consequent on the next clock
`define HRP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/hrp_pkg.sv @@
// types, codes and character helpers for the hex record parser
// no dependencies
package hrp_pkg;

    localparam int MAX_DATA_BYTES = 256;
    localparam logic [8:0] DATA_CAP = 9'(MAX_DATA_BYTES);

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_SHORT    = 2'd1;
    localparam logic [1:0] ST_BAD_CSUM = 2'd2;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;

    typedef struct packed {
        logic       item_kind;
        logic [7:0] data_value;
        logic [7:0] record_type;
        logic [7:0] record_length;
        logic [1:0] status;
    } hrp_result_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_LA && c <= CH_LF) ||
               (c >= CH_UA && c <= CH_UF);
    endfunction

    function automatic logic [3:0] hex_nib(input logic [7:0] c);
        logic [7:0] v;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            v = c - CH_ZERO;
        end else if (c >= CH_LA && c <= CH_LF) begin
            v = c - CH_LA + 8'd10;
        end else begin
            v = c - CH_UA + 8'd10;
        end
        return v[3:0];
    endfunction

    // strtoul-like conversion of two characters
    function automatic logic [7:0] conv_pair(input logic [7:0] c0, input logic [7:0] c1);
        logic [7:0] v;
        v = 8'd0;
        if (is_hex(c0)) begin
            if (is_hex(c1)) begin
                v = {hex_nib(c0), hex_nib(c1)};
            end else begin
                v = {4'd0, hex_nib(c0)};
            end
        end else if (is_ws(c0) || c0 == CH_PLUS || c0 == CH_MINUS) begin
            v = is_hex(c1) ? {4'd0, hex_nib(c1)} : 8'd0;
            if (c0 == CH_MINUS) begin
                v = 8'd0 - v;
            end
        end
        return v;
    endfunction

endpackage

@@ rtl/core/hex_record_parser_top.sv @@
// top level of the ascii hex record parser with checksum
// depends on hrp_pkg, hrp_core and hrp_out_reg
// latency: a result appears on the master side the cycle after its character transfer
// throughput: one character per cycle, sustained while the master side takes results
// the step logic sits between the parser state registers and one result register
// reset: synchronous active-low aresetn returns the parser to line start, empties output
module hex_record_parser_top import hrp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tlast,   // line_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] data_value, [15:8] record_type,
                                   // [23:16] record_length, [25:24] status, rest zero
    output logic [0:0]  m_tuser    // [0] item_kind
);

    logic        in_fire;
    logic        res_valid;
    hrp_result_t res;
    logic        out_ready;

    assign s_tready = out_ready;
    assign in_fire  = s_tvalid && out_ready;

    hrp_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .char_code (s_tdata),
        .line_end  (s_tlast),
        .res_valid (res_valid),
        .res       (res)
    );

    hrp_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (res_valid),
        .in_res   (res),
        .in_ready (out_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

@@ rtl/core/hrp_core.sv @@
// per-character parser state and step logic of the hex record parser
// depends on hrp_pkg and the shared assertion macros
`include "hex_record_parser_top_defines.svh"

module hrp_core import hrp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_fire,
    input  logic [7:0]  char_code,
    input  logic        line_end,
    output logic        res_valid,
    output hrp_result_t res
);

    localparam logic [2:0] PH_SKIP    = 3'd0;
    localparam logic [2:0] PH_LEN     = 3'd1;
    localparam logic [2:0] PH_TYPE    = 3'd2;
    localparam logic [2:0] PH_DATA    = 3'd3;
    localparam logic [2:0] PH_CSUM    = 3'd4;
    localparam logic [2:0] PH_DONE    = 3'd5;
    localparam logic [2:0] PH_COMMENT = 3'd6;

    logic [2:0] phase_reg, phase_next;
    logic [1:0] gpos_reg, gpos_next;
    logic [7:0] first_reg, first_next;
    logic [7:0] len_reg, len_next;
    logic [7:0] type_reg, type_next;
    logic [8:0] count_reg, count_next;
    logic [7:0] sum_reg, sum_next;
    logic [1:0] err_reg, err_next;

    logic [8:0] target;
    logic [8:0] len_m1;
    logic [7:0] pair_val;

    // number of data groups the length field asks for
    always_comb begin
        len_m1 = {1'b0, len_reg} - 9'd1;
        if (len_reg == 8'd0) begin
            target = 9'd0;
        end else if (len_m1 > DATA_CAP) begin
            target = DATA_CAP;
        end else begin
            target = len_m1;
        end
    end

    assign pair_val = conv_pair(first_reg, char_code);

    always_comb begin
        logic [2:0] eff_phase;
        logic       skip;
        phase_next = phase_reg;
        gpos_next  = gpos_reg;
        first_next = first_reg;
        len_next   = len_reg;
        type_next  = type_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        err_next   = err_reg;
        res_valid  = 1'b0;
        res        = '0;
        eff_phase  = phase_reg;
        skip       = 1'b0;

        if (in_fire) begin
            if (line_end) begin
                if (phase_reg != PH_COMMENT) begin
                    res_valid         = 1'b1;
                    res.item_kind     = KIND_STATUS;
                    res.record_type   = type_reg;
                    res.record_length = len_reg;
                    res.status        = (phase_reg == PH_DONE) ? err_reg : ST_SHORT;
                end
                phase_next = PH_SKIP;
                gpos_next  = 2'd0;
                first_next = 8'd0;
                len_next   = 8'd0;
                type_next  = 8'd0;
                count_next = 9'd0;
                sum_next   = 8'd0;
                err_next   = ST_OK;
            end else if (phase_reg == PH_COMMENT || phase_reg == PH_DONE) begin
                skip = 1'b1;
            end else if (char_code == CH_NUL) begin
                // decoding stops at a nul character
                err_next   = ST_SHORT;
                phase_next = PH_DONE;
            end else begin
                if (phase_reg == PH_SKIP) begin
                    if (is_ws(char_code)) begin
                        skip = 1'b1;
                    end else if (char_code == CH_BANG) begin
                        phase_next = PH_COMMENT;
                        skip       = 1'b1;
                    end else begin
                        eff_phase  = PH_LEN;
                        phase_next = PH_LEN;
                    end
                end
                if (!skip) begin
                    // group position is zero whenever the skip phase is left
                    case (gpos_reg)
                        2'd0: begin
                            first_next = char_code;
                            gpos_next  = 2'd1;
                        end
                        2'd2: begin
                            gpos_next = 2'd0;
                            if (eff_phase == PH_LEN) begin
                                phase_next = PH_TYPE;
                            end else if (eff_phase == PH_TYPE) begin
                                phase_next = (target == 9'd0) ? PH_CSUM : PH_DATA;
                            end else if (eff_phase == PH_DATA) begin
                                if (count_reg >= target) begin
                                    phase_next = PH_CSUM;
                                end
                            end
                        end
                        default: begin
                            gpos_next = 2'd2;
                            if (eff_phase == PH_LEN) begin
                                len_next = pair_val;
                            end else if (eff_phase == PH_TYPE) begin
                                type_next = pair_val;
                                sum_next  = pair_val;
                            end else if (eff_phase == PH_DATA) begin
                                sum_next       = sum_reg + pair_val;
                                count_next     = count_reg + 9'd1;
                                res_valid      = 1'b1;
                                res.item_kind  = KIND_DATA;
                                res.data_value = pair_val;
                            end else begin
                                err_next   = (pair_val == sum_reg) ? ST_OK : ST_BAD_CSUM;
                                phase_next = PH_DONE;
                                gpos_next  = 2'd0;
                            end
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SKIP;
            gpos_reg  <= 2'd0;
            first_reg <= 8'd0;
            len_reg   <= 8'd0;
            type_reg  <= 8'd0;
            count_reg <= 9'd0;
            sum_reg   <= 8'd0;
            err_reg   <= ST_OK;
        end else begin
            phase_reg <= phase_next;
            gpos_reg  <= gpos_next;
            first_reg <= first_next;
            len_reg   <= len_next;
            type_reg  <= type_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
            err_reg   <= err_next;
        end
    end

    `HRP_ASSERT_NEXT(a_line_end_clears, in_fire && line_end, phase_reg == PH_SKIP && count_reg == 9'd0 && gpos_reg == 2'd0, "line end did not return parser to line start")
    `HRP_ASSERT(a_count_in_range, phase_reg != PH_DATA || count_reg <= target, "data count ran past the record length")
    `HRP_ASSERT(a_skip_at_group_start, phase_reg != PH_SKIP || gpos_reg == 2'd0, "group position nonzero during whitespace skip")
    `HRP_ASSERT(a_result_needs_transfer, !res_valid || in_fire, "result raised without an input transfer")

endmodule

@@ rtl/core/hrp_out_reg.sv @@
// result register of the hex record parser, packs the master-side stream
// depends on hrp_pkg and the shared assertion macros
`include "hex_record_parser_top_defines.svh"

module hrp_out_reg import hrp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    input  hrp_result_t in_res,
    output logic        in_ready,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,
    output logic [0:0]  m_tuser
);

    logic        valid_reg;
    hrp_result_t res_reg;

    // a new result may enter when the register is empty or while the held one is taken
    assign in_ready = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            res_reg <= in_res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {6'd0, res_reg.status, res_reg.record_length,
                       res_reg.record_type, res_reg.data_value};
    assign m_tuser  = res_reg.item_kind;

    `HRP_ASSERT_NEXT(a_load_shows, in_valid && in_ready, valid_reg, "accepted result not presented")
    `HRP_ASSERT(a_stall_only_full, in_ready || valid_reg, "input stalled with empty result register")
    `HRP_ASSERT(a_data_item_clean, !valid_reg || res_reg.item_kind == KIND_STATUS || (res_reg.status == ST_OK && res_reg.record_type == 8'd0), "data item carries status fields")

endmodule
